// ----- hw/rtl/bcd_alarm_clock_controller_macros.svh -----
// ----------------------------------------------------------------------------
// bcd alarm clock controller assertion macros
// property shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef BCD_ALARM_CLOCK_CONTROLLER_MACROS_SVH
`define BCD_ALARM_CLOCK_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BACC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bacc_pkg.sv -----
// ----------------------------------------------------------------------------
// bacc_pkg
// types, codes and constants of the bcd alarm clock controller
// ----------------------------------------------------------------------------
`default_nettype none

package bacc_pkg;

    // operating mode
    typedef enum logic [1:0] {
        MODE_RUN       = 2'd0,
        MODE_CLOCK_SET = 2'd1,
        MODE_ALARM_SET = 2'd2
    } t_mode;

    // selected time field
    typedef enum logic [1:0] {
        FIELD_HOUR = 2'd0,
        FIELD_MIN  = 2'd1,
        FIELD_SEC  = 2'd2
    } t_field;

    // beat kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // key codes
    localparam logic [1:0] KEY_SEL_CLOCK = 2'd0;
    localparam logic [1:0] KEY_SEL_ALARM = 2'd1;
    localparam logic [1:0] KEY_UP        = 2'd2;
    localparam logic [1:0] KEY_DOWN      = 2'd3;

    // register map (word index)
    localparam int          ADDR_W          = 4;
    localparam logic [1:0]  REG_FRAME_TICKS = 2'd0;
    localparam logic [1:0]  REG_BLINK_TICKS = 2'd1;
    localparam logic [1:0]  REG_RING_TICKS  = 2'd2;

    // register reset values
    localparam logic [7:0]  FRAME_TICKS_RST = 8'd100;
    localparam logic [9:0]  BLINK_TICKS_RST = 10'd500;
    localparam logic [11:0] RING_TICKS_RST  = 12'd2500;

    // bcd limits
    localparam logic [3:0] BCD_DIGIT_OVF  = 4'hA;
    localparam logic [3:0] BCD_DIGIT_UNF  = 4'hF;
    localparam logic [3:0] BCD_DIGIT_MAX  = 4'h9;
    localparam logic [7:0] BCD_HOUR_END   = 8'h24;
    localparam logic [7:0] BCD_MINSEC_END = 8'h60;
    localparam logic [7:0] BCD_UNDER      = 8'hF9;
    localparam logic [7:0] BCD_HOUR_MAX   = 8'h23;
    localparam logic [7:0] BCD_MINSEC_MAX = 8'h59;

    typedef logic [2:0][7:0] t_time;

    // configuration registers
    typedef struct packed {
        logic [7:0]  frame_ticks;
        logic [9:0]  blink_ticks;
        logic [11:0] ring_ticks;
    } t_cfg;

    // one input beat
    typedef struct packed {
        logic       opcode;
        logic [1:0] key_code;
        logic [7:0] rtc_hour;
        logic [7:0] rtc_min;
        logic [7:0] rtc_sec;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [7:0] show_hour;
        logic [7:0] show_min;
        logic [7:0] show_sec;
        logic       blank_field;
        logic [1:0] mode_now;
        logic [1:0] field_sel;
        logic       led_on;
        logic       rtc_write;
        logic       frame_done;
    } t_res;

    // bcd increment with wrap at 24 or 60
    function automatic logic [7:0] bcd_up(input logic [7:0] v, input logic is_hour);
        logic [7:0] r;
        r = v + 8'd1;
        if (r[3:0] == BCD_DIGIT_OVF) begin
            r = {r[7:4] + 4'd1, 4'h0};
        end
        if (r == (is_hour ? BCD_HOUR_END : BCD_MINSEC_END)) begin
            r = 8'h00;
        end
        return r;
    endfunction

    // bcd decrement with wrap to 23 or 59
    function automatic logic [7:0] bcd_down(input logic [7:0] v, input logic is_hour);
        logic [7:0] r;
        r = v - 8'd1;
        if (r[3:0] == BCD_DIGIT_UNF) begin
            r = {r[7:4], BCD_DIGIT_MAX};
        end
        if (r == BCD_UNDER) begin
            r = is_hour ? BCD_HOUR_MAX : BCD_MINSEC_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bacc_in_if.sv -----
// ----------------------------------------------------------------------------
// bacc_in_if
// input channel: ticks with rtc time and key presses
// ----------------------------------------------------------------------------
`default_nettype none

interface bacc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [1:0] key_code;
    logic [7:0] rtc_hour;
    logic [7:0] rtc_min;
    logic [7:0] rtc_sec;

    modport source (
        output valid, opcode, key_code, rtc_hour, rtc_min, rtc_sec,
        input  ready
    );

    modport sink (
        input  valid, opcode, key_code, rtc_hour, rtc_min, rtc_sec,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/bacc_out_if.sv -----
// ----------------------------------------------------------------------------
// bacc_out_if
// result channel: shown time, mode and status flags
// ----------------------------------------------------------------------------
`default_nettype none

interface bacc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] show_hour;
    logic [7:0] show_min;
    logic [7:0] show_sec;
    logic       blank_field;
    logic [1:0] mode_now;
    logic [1:0] field_sel;
    logic       led_on;
    logic       rtc_write;
    logic       frame_done;

    modport source (
        output valid, show_hour, show_min, show_sec, blank_field, mode_now,
               field_sel, led_on, rtc_write, frame_done,
        input  ready
    );

    modport sink (
        input  valid, show_hour, show_min, show_sec, blank_field, mode_now,
               field_sel, led_on, rtc_write, frame_done,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/bacc_core.sv -----
// ----------------------------------------------------------------------------
// bacc_core
// clock state and single-beat update: dividers, mode, field, times, alarm
// ----------------------------------------------------------------------------
`default_nettype none

module bacc_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire bacc_pkg::t_item i_item,
    input  wire bacc_pkg::t_cfg  i_cfg,
    output bacc_pkg::t_res       o_res
);
    import bacc_pkg::*;

    t_mode       r_mode,          n_mode;
    t_field      r_field,         n_field;
    t_time       r_clock,         n_clock;
    t_time       r_alarm,         n_alarm;
    logic        r_ringing,       n_ringing;
    logic        r_reload,        n_reload;
    logic [7:0]  r_frame_count,   n_frame_count;
    logic [9:0]  r_blink_count,   n_blink_count;
    logic [11:0] r_ring_count,    n_ring_count;
    logic        r_led_phase,     n_led_phase;
    logic        r_blink_phase,   n_blink_phase;

    logic [7:0]  frame_inc;
    logic [9:0]  blink_inc;
    logic [11:0] ring_inc;
    logic        frame;
    logic        rtc_wr;
    t_time       rtc_time;
    t_time       cmp_time;
    t_time       edit_time;
    t_time       shown;
    logic [7:0]  edit_cur;
    logic [7:0]  edit_new;
    logic        is_hour;

    assign frame_inc   = r_frame_count + 8'd1;
    assign blink_inc   = r_blink_count + 10'd1;
    assign ring_inc    = r_ring_count + 12'd1;
    assign rtc_time[0] = i_item.rtc_hour;
    assign rtc_time[1] = i_item.rtc_min;
    assign rtc_time[2] = i_item.rtc_sec;

    // field being edited by up and down keys
    assign edit_time = (r_mode == MODE_CLOCK_SET) ? r_clock : r_alarm;
    assign edit_cur  = edit_time[r_field];
    assign is_hour   = (r_field == FIELD_HOUR);
    assign edit_new  = (i_item.key_code == KEY_UP) ? bcd_up(edit_cur, is_hour)
                                                   : bcd_down(edit_cur, is_hour);
    assign cmp_time  = r_reload ? rtc_time : r_clock;

    // next state for one beat
    always_comb begin
        n_mode        = r_mode;
        n_field       = r_field;
        n_clock       = r_clock;
        n_alarm       = r_alarm;
        n_ringing     = r_ringing;
        n_reload      = r_reload;
        n_frame_count = r_frame_count;
        n_blink_count = r_blink_count;
        n_ring_count  = r_ring_count;
        n_led_phase   = r_led_phase;
        n_blink_phase = r_blink_phase;
        frame         = 1'b0;
        rtc_wr        = 1'b0;

        if (i_item.opcode == OP_TICK) begin
            // frame divider
            if (frame_inc >= i_cfg.frame_ticks) begin
                n_frame_count = '0;
                n_led_phase   = ~r_led_phase;
                frame         = 1'b1;
            end else begin
                n_frame_count = frame_inc;
            end
            // blink divider
            if (blink_inc >= i_cfg.blink_ticks) begin
                n_blink_count = '0;
                n_blink_phase = ~r_blink_phase;
            end else begin
                n_blink_count = blink_inc;
            end
            // ringing timeout
            if (r_ringing) begin
                if (ring_inc >= i_cfg.ring_ticks) begin
                    n_ringing    = 1'b0;
                    n_ring_count = '0;
                end else begin
                    n_ring_count = ring_inc;
                end
            end else begin
                n_ring_count = '0;
            end
            // frame work: alarm compare and clock reload
            if (frame) begin
                unique case (r_mode)
                    MODE_RUN: begin
                        if (cmp_time == r_alarm) begin
                            n_ringing = 1'b1;
                        end
                        n_clock  = rtc_time;
                        n_reload = 1'b0;
                    end
                    MODE_CLOCK_SET: begin
                        if (r_reload) begin
                            n_clock  = rtc_time;
                            n_reload = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            unique case (r_mode)
                MODE_RUN: begin
                    if (r_ringing) begin
                        n_ringing    = 1'b0;
                        n_ring_count = '0;
                    end else if (i_item.key_code == KEY_SEL_CLOCK) begin
                        n_mode   = MODE_CLOCK_SET;
                        n_field  = FIELD_HOUR;
                        n_reload = 1'b1;
                    end else if (i_item.key_code == KEY_SEL_ALARM) begin
                        n_mode  = MODE_ALARM_SET;
                        n_field = FIELD_HOUR;
                    end
                end
                default: begin
                    if ((i_item.key_code == KEY_SEL_CLOCK && r_mode == MODE_CLOCK_SET) ||
                        (i_item.key_code == KEY_SEL_ALARM && r_mode == MODE_ALARM_SET)) begin
                        // advance field, back to run after seconds
                        unique case (r_field)
                            FIELD_HOUR: n_field = FIELD_MIN;
                            FIELD_MIN:  n_field = FIELD_SEC;
                            default: begin
                                n_field = FIELD_HOUR;
                                n_mode  = MODE_RUN;
                            end
                        endcase
                    end else if (i_item.key_code == KEY_UP ||
                                 i_item.key_code == KEY_DOWN) begin
                        if (r_mode == MODE_CLOCK_SET) begin
                            n_clock[r_field] = edit_new;
                            rtc_wr           = 1'b1;
                        end else begin
                            n_alarm[r_field] = edit_new;
                        end
                    end
                end
            endcase
        end
    end

    // result from the updated state
    assign shown = (n_mode == MODE_ALARM_SET) ? n_alarm : n_clock;

    always_comb begin
        o_res.show_hour   = shown[0];
        o_res.show_min    = shown[1];
        o_res.show_sec    = shown[2];
        o_res.blank_field = (n_mode != MODE_RUN) && !n_blink_phase;
        o_res.mode_now    = n_mode;
        o_res.field_sel   = n_field;
        o_res.led_on      = n_ringing && n_led_phase && (n_mode == MODE_RUN);
        o_res.rtc_write   = rtc_wr;
        o_res.frame_done  = frame;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_RUN;
            r_field       <= FIELD_HOUR;
            r_clock       <= '0;
            r_alarm       <= '0;
            r_ringing     <= 1'b0;
            r_reload      <= 1'b1;
            r_frame_count <= '0;
            r_blink_count <= '0;
            r_ring_count  <= '0;
            r_led_phase   <= 1'b0;
            r_blink_phase <= 1'b1;
        end else if (i_en) begin
            r_mode        <= n_mode;
            r_field       <= n_field;
            r_clock       <= n_clock;
            r_alarm       <= n_alarm;
            r_ringing     <= n_ringing;
            r_reload      <= n_reload;
            r_frame_count <= n_frame_count;
            r_blink_count <= n_blink_count;
            r_ring_count  <= n_ring_count;
            r_led_phase   <= n_led_phase;
            r_blink_phase <= n_blink_phase;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bcd_alarm_clock_controller.sv -----
// ----------------------------------------------------------------------------
// bcd_alarm_clock_controller
// alarm clock mode, time setting and alarm control driven by ticks and keys
// ----------------------------------------------------------------------------
// Each input beat (a 2 ms tick carrying the rtc time, or a key press) yields
// exactly one result beat. A beat is captured in an input register, the
// state update and result run through one short combinational step in
// bacc_core, and the result lands in an output register. One beat is
// accepted every cycle as long as the result side keeps taking beats; the
// input stalls only when both registers hold beats the sink has not taken.
// The user must write registers frame_ticks (0x0), blink_ticks (0x4) and
// ring_ticks (0x8) over the apb port only while no beat is in flight; the
// block does not enforce this. There is no clearing pass after reset.
`default_nettype none

module bcd_alarm_clock_controller (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    bacc_in_if.sink                        i_in,
    bacc_out_if.source                     o_out,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [bacc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import bacc_pkg::*;

    t_cfg   r_cfg;
    t_item  r_item;
    logic   r_in_valid;
    t_res   r_res;
    t_res   core_res;
    logic   r_out_valid;
    logic   advance;
    logic   in_take;
    logic   cfg_wr;
    logic [1:0] reg_idx;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_ticks <= FRAME_TICKS_RST;
            r_cfg.blink_ticks <= BLINK_TICKS_RST;
            r_cfg.ring_ticks  <= RING_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_TICKS: r_cfg.frame_ticks <= pwdata[7:0];
                REG_BLINK_TICKS: r_cfg.blink_ticks <= pwdata[9:0];
                REG_RING_TICKS:  r_cfg.ring_ticks  <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_TICKS: prdata = {24'd0, r_cfg.frame_ticks};
            REG_BLINK_TICKS: prdata = {22'd0, r_cfg.blink_ticks};
            REG_RING_TICKS:  prdata = {20'd0, r_cfg.ring_ticks};
            default:         prdata = '0;
        endcase
    end

    // pipeline flow: the step runs when the result register can take it
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.opcode   <= i_in.opcode;
            r_item.key_code <= i_in.key_code;
            r_item.rtc_hour <= i_in.rtc_hour;
            r_item.rtc_min  <= i_in.rtc_min;
            r_item.rtc_sec  <= i_in.rtc_sec;
        end
    end

    // state update and result
    bacc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && advance),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_res <= core_res;
        end
    end

    // result beat
    assign o_out.valid       = r_out_valid;
    assign o_out.show_hour   = r_res.show_hour;
    assign o_out.show_min    = r_res.show_min;
    assign o_out.show_sec    = r_res.show_sec;
    assign o_out.blank_field = r_res.blank_field;
    assign o_out.mode_now    = r_res.mode_now;
    assign o_out.field_sel   = r_res.field_sel;
    assign o_out.led_on      = r_res.led_on;
    assign o_out.rtc_write   = r_res.rtc_write;
    assign o_out.frame_done  = r_res.frame_done;

endmodule

`default_nettype wire

// ----- hw/rtl/bacc_checker.sv -----
// ----------------------------------------------------------------------------
// bacc_checker
// port-level checks of the bcd alarm clock controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "bcd_alarm_clock_controller_macros.svh"

module bacc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_show_hour,
    input wire logic       i_blank_field,
    input wire logic [1:0] i_mode_now,
    input wire logic       i_led_on,
    input wire logic       i_rtc_write,
    input wire logic       i_frame_done
);
    import bacc_pkg::*;

    // a stalled result beat holds its valid and shown hour
    `BACC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_show_hour), "result beat dropped or changed while stalled")

    // no blanking in run mode
    `BACC_ASSERT_NOW(a_no_blank_run, i_clk, i_rst_n, i_out_valid && i_mode_now == MODE_RUN, !i_blank_field, "field blanked in run mode")

    // rtc write only on a key in clock set mode
    `BACC_ASSERT_NOW(a_rtc_write_mode, i_clk, i_rst_n, i_out_valid && i_rtc_write, i_mode_now == MODE_CLOCK_SET && !i_frame_done, "rtc write outside clock set key beat")

    // alarm led only in run mode
    `BACC_ASSERT_NOW(a_led_run, i_clk, i_rst_n, i_out_valid && i_led_on, i_mode_now == MODE_RUN, "alarm led lit outside run mode")

endmodule

bind bcd_alarm_clock_controller bacc_checker u_bacc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_show_hour   (o_out.show_hour),
    .i_blank_field (o_out.blank_field),
    .i_mode_now    (o_out.mode_now),
    .i_led_on      (o_out.led_on),
    .i_rtc_write   (o_out.rtc_write),
    .i_frame_done  (o_out.frame_done)
);

`default_nettype wire
